/* rtl/kuz_pkg.sv */
// kuz_pkg: shared types, constants and round functions for the block cipher unit
// no dependencies
`timescale 1ns / 1ps
package kuz_pkg;

    localparam int RK_COUNT     = 10;
    localparam int SCHED_STEPS  = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR  = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_ROUND
    } kuz_state_t;

    typedef logic [7:0] sbox_t [256];

    localparam sbox_t SBOX_FWD = '{
        8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
        8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
        8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
        8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
        8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
        8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
        8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
        8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
        8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
        8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
        8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
        8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
        8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
        8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
        8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
        8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6
    };

    localparam sbox_t SBOX_INV = '{
        8'hA5,8'h2D,8'h32,8'h8F,8'h0E,8'h30,8'h38,8'hC0,8'h54,8'hE6,8'h9E,8'h39,8'h55,8'h7E,8'h52,8'h91,
        8'h64,8'h03,8'h57,8'h5A,8'h1C,8'h60,8'h07,8'h18,8'h21,8'h72,8'hA8,8'hD1,8'h29,8'hC6,8'hA4,8'h3F,
        8'hE0,8'h27,8'h8D,8'h0C,8'h82,8'hEA,8'hAE,8'hB4,8'h9A,8'h63,8'h49,8'hE5,8'h42,8'hE4,8'h15,8'hB7,
        8'hC8,8'h06,8'h70,8'h9D,8'h41,8'h75,8'h19,8'hC9,8'hAA,8'hFC,8'h4D,8'hBF,8'h2A,8'h73,8'h84,8'hD5,
        8'hC3,8'hAF,8'h2B,8'h86,8'hA7,8'hB1,8'hB2,8'h5B,8'h46,8'hD3,8'h9F,8'hFD,8'hD4,8'h0F,8'h9C,8'h2F,
        8'h9B,8'h43,8'hEF,8'hD9,8'h79,8'hB6,8'h53,8'h7F,8'hC1,8'hF0,8'h23,8'hE7,8'h25,8'h5E,8'hB5,8'h1E,
        8'hA2,8'hDF,8'hA6,8'hFE,8'hAC,8'h22,8'hF9,8'hE2,8'h4A,8'hBC,8'h35,8'hCA,8'hEE,8'h78,8'h05,8'h6B,
        8'h51,8'hE1,8'h59,8'hA3,8'hF2,8'h71,8'h56,8'h11,8'h6A,8'h89,8'h94,8'h65,8'h8C,8'hBB,8'h77,8'h3C,
        8'h7B,8'h28,8'hAB,8'hD2,8'h31,8'hDE,8'hC4,8'h5F,8'hCC,8'hCF,8'h76,8'h2C,8'hB8,8'hD8,8'h2E,8'h36,
        8'hDB,8'h69,8'hB3,8'h14,8'h95,8'hBE,8'h62,8'hA1,8'h3B,8'h16,8'h66,8'hE9,8'h5C,8'h6C,8'h6D,8'hAD,
        8'h37,8'h61,8'h4B,8'hB9,8'hE3,8'hBA,8'hF1,8'hA0,8'h85,8'h83,8'hDA,8'h47,8'hC5,8'hB0,8'h33,8'hFA,
        8'h96,8'h6F,8'h6E,8'hC2,8'hF6,8'h50,8'hFF,8'h5D,8'hA9,8'h8E,8'h17,8'h1B,8'h97,8'h7D,8'hEC,8'h58,
        8'hF7,8'h1F,8'hFB,8'h7C,8'h09,8'h0D,8'h7A,8'h67,8'h45,8'h87,8'hDC,8'hE8,8'h4F,8'h1D,8'h4E,8'h04,
        8'hEB,8'hF8,8'hF3,8'h3E,8'h3D,8'hBD,8'h8A,8'h88,8'hDD,8'hCD,8'h0B,8'h13,8'h98,8'h02,8'h93,8'h80,
        8'h90,8'hD0,8'h24,8'h34,8'hCB,8'hED,8'hF4,8'hCE,8'h99,8'h10,8'h44,8'h40,8'h92,8'h3A,8'h01,8'h26,
        8'h12,8'h1A,8'h48,8'h68,8'hF5,8'h81,8'h8B,8'hC7,8'hD6,8'h20,8'h0A,8'h08,8'h00,8'h4C,8'hD7,8'h74
    };

    typedef logic [7:0] coef_t [16];
    localparam coef_t LIN_COEF = '{
        8'h94,8'h20,8'h85,8'h10,8'hC2,8'hC0,8'h01,8'hFB,
        8'h01,8'hC0,8'hC2,8'h10,8'h85,8'h20,8'h94,8'h01
    };

    // multiply by a constant in GF(2^8) mod 0x1C3; constant operand folds to xor network
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] r;
        x = a;
        r = 8'h00;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
                r = r ^ x;
            x = x[7] ? ((x << 1) ^ 8'hC3) : (x << 1);
        end
        return r;
    endfunction

    // byte i of the block sits at bits [127-8i -: 8]
    function automatic logic [7:0] lfsr_sum(input logic [127:0] v);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 16; i++)
            acc = acc ^ gf_mul(v[127-8*i -: 8], LIN_COEF[i]);
        return acc;
    endfunction

    function automatic logic [127:0] lin_fwd(input logic [127:0] v);
        logic [127:0] w;
        w = v;
        for (int n = 0; n < 16; n++)
            w = {lfsr_sum(w), w[127:8]};
        return w;
    endfunction

    function automatic logic [127:0] lin_inv(input logic [127:0] v);
        logic [127:0] w;
        logic [7:0]   acc;
        w = v;
        for (int n = 0; n < 16; n++)
        begin
            acc = lfsr_sum({w[119:0], 8'h00}) ^ w[127:120];
            w = {w[119:0], acc};
        end
        return w;
    endfunction

    function automatic logic [127:0] sub_fwd(input logic [127:0] v);
        logic [127:0] w;
        for (int i = 0; i < 16; i++)
            w[8*i +: 8] = SBOX_FWD[v[8*i +: 8]];
        return w;
    endfunction

    function automatic logic [127:0] sub_inv(input logic [127:0] v);
        logic [127:0] w;
        for (int i = 0; i < 16; i++)
            w[8*i +: 8] = SBOX_INV[v[8*i +: 8]];
        return w;
    endfunction

endpackage

/* rtl/kuz_round.sv */
// kuz_round: one cipher round (forward x-s-l, bare x when last, or inverse l^-1 s^-1 x) as xor networks
// depends on kuz_pkg
`timescale 1ns / 1ps
module kuz_round
    import kuz_pkg::*;
(
    input  logic [127:0] state,
    input  logic [127:0] round_key,
    input  logic         inverse,
    input  logic         last,
    output logic [127:0] result
);

    logic [127:0] fwd_x;

    assign fwd_x = state ^ round_key;

    always_comb
    begin
        if (inverse)
            result = sub_inv(lin_inv(state)) ^ round_key;
        else if (last)
            result = fwd_x;
        else
            result = lin_fwd(sub_fwd(fwd_x));
    end

endmodule

/* rtl/kuznyechik_block_cipher_unit.sv */
// kuznyechik_block_cipher_unit: gost 128-bit block cipher, round keys in a 10x128 memory
// depends on kuz_pkg and kuz_round
// one round per cycle, round keys read in sequence
// after a key write the next item first runs 32 schedule steps
// one item at a time: input is taken only in idle and waits until the held result is taken
// reset: asynchronous low, clears control, key words and key-valid state; key memory holds no reset
`timescale 1ns / 1ps
module kuznyechik_block_cipher_unit
    import kuz_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [127:0]           s_axis_tdata,   // data_high[63:0], data_low[127:64]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [127:0]           m_axis_tdata,   // result_high[63:0], result_low[127:64]
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int KW = $clog2(RK_COUNT);

    logic [63:0]   key_reg [4];
    logic          dir_reg;
    logic          ready_keys_reg;

    logic [127:0]  rk_mem [RK_COUNT];
    logic [127:0]  rk_rd_reg;

    kuz_state_t    state_reg, state_next;
    logic [127:0]  blk_reg, blk_next;
    logic [127:0]  a1_reg, a1_next, a0_reg, a0_next;
    logic [5:0]    step_reg, step_next;
    logic [KW-1:0] rnd_reg, rnd_next;
    logic [127:0]  out_reg;
    logic          out_valid_reg;

    logic [127:0]  round_out;
    logic [127:0]  cst;
    logic [127:0]  sched_t;
    logic [5:0]    step_inc;
    logic          xor_only;
    logic          round_last;
    logic          mem_we;
    logic [KW-1:0] mem_waddr;
    logic [127:0]  mem_wdata;
    logic [KW-1:0] mem_raddr;

    // encrypt ends with a bare key add, decrypt starts with one
    assign xor_only   = dir_reg ? (rnd_reg == '0) : (rnd_reg == KW'(RK_COUNT - 1));
    assign round_last = (state_reg == ST_ROUND) && (rnd_reg == KW'(RK_COUNT - 1));

    kuz_round u_round (
        .state     (blk_reg),
        .round_key (rk_rd_reg),
        .inverse   (dir_reg && (rnd_reg != '0)),
        .last      (xor_only),
        .result    (round_out)
    );

    assign cst      = lin_fwd({120'd0, 2'b00, step_reg});
    assign sched_t  = lin_fwd(sub_fwd(a1_reg ^ cst)) ^ a0_reg;
    assign step_inc = step_reg + 6'd1;

    // key for the round that runs next cycle
    assign mem_raddr = dir_reg ? (KW'(RK_COUNT - 1) - rnd_next) : rnd_next;

    assign s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg[63:0], out_reg[127:64]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0]     <= '0;
            key_reg[1]     <= '0;
            key_reg[2]     <= '0;
            key_reg[3]     <= '0;
            dir_reg        <= 1'b0;
            ready_keys_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KEY0: begin key_reg[0] <= cfg_data; ready_keys_reg <= 1'b0; end
                    REG_KEY1: begin key_reg[1] <= cfg_data; ready_keys_reg <= 1'b0; end
                    REG_KEY2: begin key_reg[2] <= cfg_data; ready_keys_reg <= 1'b0; end
                    REG_KEY3: begin key_reg[3] <= cfg_data; ready_keys_reg <= 1'b0; end
                    REG_DIR:  dir_reg <= cfg_data[0];
                    default:  ;
                endcase
            end
            else if (state_reg == ST_EXPAND && step_reg == 6'(SCHED_STEPS))
                ready_keys_reg <= 1'b1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_axis_tvalid && s_axis_tready)
                    state_next = ready_keys_reg ? ST_ROUND : ST_EXPAND;
            ST_EXPAND:
                if (step_reg == 6'(SCHED_STEPS))
                    state_next = ST_ROUND;
            ST_ROUND:
                if (rnd_reg == KW'(RK_COUNT - 1))
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        blk_next  = blk_reg;
        a1_next   = a1_reg;
        a0_next   = a0_reg;
        step_next = step_reg;
        rnd_next  = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = sched_t;
        case (state_reg)
            ST_IDLE:
            begin
                blk_next  = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
                a1_next   = {key_reg[0], key_reg[1]};
                a0_next   = {key_reg[2], key_reg[3]};
                step_next = 6'd1;
            end
            ST_EXPAND:
            begin
                a1_next   = sched_t;
                a0_next   = a1_reg;
                step_next = step_inc;
                // the key halves fill entries 0 and 1 during the first two steps;
                // each later pair is stored one word per step as it comes out
                if (step_reg == 6'd1)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = {key_reg[0], key_reg[1]};
                end
                else if (step_reg == 6'd2)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = KW'(1);
                    mem_wdata = {key_reg[2], key_reg[3]};
                end
                else if (step_reg[2:0] == 3'd7)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = KW'(step_inc[5:2]) + KW'(1);
                end
                else if (step_reg[2:0] == 3'd0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = KW'(step_reg[5:2]);
                end
            end
            ST_ROUND:
            begin
                blk_next = round_out;
                if (rnd_reg != KW'(RK_COUNT - 1))
                    rnd_next = rnd_reg + KW'(1);
            end
            default: ;
        endcase
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            rnd_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            rnd_reg   <= rnd_next;
            if (round_last)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        a1_reg  <= a1_next;
        a0_reg  <= a0_next;
        if (round_last)
            out_reg <= round_out;
    end

    // key memory: one write port, one registered read port, one round key per entry
    always_ff @(posedge clk)
    begin
        if (mem_we)
            rk_mem[mem_waddr] <= mem_wdata;
        rk_rd_reg <= rk_mem[mem_raddr];
    end

endmodule

/* bench/tb_kuznyechik_block_cipher_unit.sv */
// tb_kuznyechik_block_cipher_unit: self-checking bench for the 128-bit block cipher unit
// depends on kuz_pkg and kuznyechik_block_cipher_unit; predicts every block from its own model
`timescale 1ns / 1ps
module tb_kuznyechik_block_cipher_unit
    import kuz_pkg::*;
();

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } block_t;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE5 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 150;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 160;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    kuznyechik_block_cipher_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [63:0]  key_words [4];
    logic         decrypt = 1'b0;
    logic         schedule_valid = 1'b0;
    logic [127:0] key_sched [RK_COUNT];
    logic [7:0]   sbox_back [256];

    block_t blocks_to_send [$];
    block_t blocks_expected [$];

    int  mismatches = 0;
    int  results_seen = 0;
    bit  quiet = 1'b0;
    int  send_gap = 0;
    int  recv_stall = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] x;
        logic [7:0] r;
        x = {1'b0, a};
        r = 8'h00;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
                r ^= x[7:0];
            x = x << 1;
            if (x[8])
                x ^= 9'h1C3;
        end
        return r;
    endfunction

    function automatic logic [7:0] mix_weight(input int i);
        logic [7:0] w [16] = '{8'h94, 8'h20, 8'h85, 8'h10, 8'hC2, 8'hC0, 8'h01, 8'hFB,
                               8'h01, 8'hC0, 8'hC2, 8'h10, 8'h85, 8'h20, 8'h94, 8'h01};
        return w[i];
    endfunction

    // byte 0 of the block is the top byte
    function automatic logic [127:0] mix_fwd(input logic [127:0] v);
        logic [7:0] acc;
        for (int n = 0; n < 16; n++)
        begin
            acc = 8'h00;
            for (int i = 0; i < 16; i++)
                acc ^= gf_times(v[127-8*i -: 8], mix_weight(i));
            v = {acc, v[127:8]};
        end
        return v;
    endfunction

    function automatic logic [127:0] mix_inv(input logic [127:0] v);
        logic [7:0] acc;
        for (int n = 0; n < 16; n++)
        begin
            acc = v[127:120];
            v = {v[119:0], 8'h00};
            for (int i = 0; i < 15; i++)
                acc ^= gf_times(v[127-8*i -: 8], mix_weight(i));
            v[7:0] = acc;
        end
        return v;
    endfunction

    function automatic logic [127:0] subst(input logic [127:0] v, input bit back);
        for (int i = 0; i < 16; i++)
            v[8*i +: 8] = back ? sbox_back[v[8*i +: 8]] : SBOX_FWD[v[8*i +: 8]];
        return v;
    endfunction

    function automatic void build_key_sched();
        logic [127:0] a1, a0, t;
        a1 = {key_words[0], key_words[1]};
        a0 = {key_words[2], key_words[3]};
        key_sched[0] = a1;
        key_sched[1] = a0;
        for (int i = 1; i <= 32; i++)
        begin
            t = mix_fwd(subst(a1 ^ mix_fwd(128'(i)), 1'b0)) ^ a0;
            a0 = a1;
            a1 = t;
            if (i % 8 == 0)
            begin
                key_sched[i / 4]     = a1;
                key_sched[i / 4 + 1] = a0;
            end
        end
        schedule_valid = 1'b1;
    endfunction

    function automatic block_t cipher_block(input block_t b);
        logic [127:0] v;
        block_t o;
        if (!schedule_valid)
            build_key_sched();
        v = {b.hi, b.lo};
        if (!decrypt)
        begin
            for (int r = 0; r < RK_COUNT - 1; r++)
                v = mix_fwd(subst(v ^ key_sched[r], 1'b0));
            v ^= key_sched[RK_COUNT-1];
        end
        else
        begin
            v ^= key_sched[RK_COUNT-1];
            for (int r = RK_COUNT - 2; r >= 0; r--)
                v = subst(mix_inv(v), 1'b1) ^ key_sched[r];
        end
        o.hi = v[127:64];
        o.lo = v[63:0];
        return o;
    endfunction

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 64'h0;
            1: return '1;
            2: return 64'h1 << $urandom_range(0, 63);
            3: return ~(64'h1 << $urandom_range(0, 63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3:
            begin
                key_words[idx] = value;
                schedule_valid = 1'b0;
            end
            REG_DIR: decrypt = value[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (blocks_to_send.size() != 0 || s_axis_tvalid || blocks_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_block(input logic [63:0] hi, input logic [63:0] lo);
        block_t b;
        b.hi = hi;
        b.lo = lo;
        blocks_to_send.push_back(b);
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("FAIL");
        $finish;
    end

    // sender: one item held until accepted, random gaps between items unless quiet
    always @(posedge clk or negedge rst_n)
    begin
        block_t b;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                b.hi = s_axis_tdata[63:0];
                b.lo = s_axis_tdata[127:64];
                blocks_expected.push_back(cipher_block(b));
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (blocks_to_send.size() != 0)
                begin
                    b = blocks_to_send.pop_front();
                    s_axis_tdata  <= {b.lo, b.hi};
                    s_axis_tvalid <= 1'b1;
                    if (!quiet && $urandom_range(0, 4) == 0)
                        send_gap = $urandom_range(1, 3);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: short random stalls unless quiet, one long hold to back the block up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!hold_done && results_seen >= 300)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else if (recv_stall > 0)
        begin
            recv_stall--;
            m_axis_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            recv_stall = $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        block_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (blocks_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: hi=%h lo=%h",
                             m_axis_tdata[63:0], m_axis_tdata[127:64]);
            end
            else
            begin
                want = blocks_expected.pop_front();
                if (m_axis_tdata[63:0] !== want.hi)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result_high mismatch: expected %h, got %h",
                                 want.hi, m_axis_tdata[63:0]);
                end
                if (m_axis_tdata[127:64] !== want.lo)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result_low mismatch: expected %h, got %h",
                                 want.lo, m_axis_tdata[127:64]);
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < 4; i++)
            key_words[i] = 64'h0;
        for (int i = 0; i < 256; i++)
            sbox_back[SBOX_FWD[i]] = 8'(i);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // zero key straight out of reset, no register written yet
        queue_block(64'h0, 64'h0);
        queue_block('1, '1);
        queue_block(64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555);
        wait_drained();

        // published test key and block, encrypt then decrypt
        write_reg(REG_KEY0, 64'h8899AABBCCDDEEFF);
        write_reg(REG_KEY1, 64'h0011223344556677);
        write_reg(REG_KEY2, 64'hFEDCBA9876543210);
        write_reg(REG_KEY3, 64'h0123456789ABCDEF);
        queue_block(64'h1122334455667700, 64'hFFEEDDCCBBAA9988);
        queue_block(64'h8000000000000000, 64'h0000000000000001);
        queue_block(64'h0, '1);
        wait_drained();
        // only bit 0 of direction counts
        write_reg(REG_DIR, 64'hFFFFFFFFFFFFFFF1);
        queue_block(64'h7F679D90BEBC2430, 64'h5A468D42B9D4EDCD);
        queue_block(64'h0, 64'h0);
        queue_block('1, 64'h0);
        wait_drained();

        // all-ones key, spare indexes must change nothing
        write_reg(REG_KEY0, '1);
        write_reg(REG_KEY1, '1);
        write_reg(REG_KEY2, '1);
        write_reg(REG_KEY3, '1);
        write_reg(REG_SPARE5, '1);
        write_reg(REG_SPARE6, 64'h1);
        write_reg(REG_SPARE7, 64'h0123456789ABCDEF);
        queue_block('1, '1);
        queue_block(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
        wait_drained();
        write_reg(REG_DIR, 64'hFFFFFFFFFFFFFFFE);
        queue_block('1, '1);
        queue_block(64'h0, 64'h1);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            // rewrite a random subset of key words, always at least one
            for (int w = 0; w < 4; w++)
                if (p < 2 || $urandom_range(0, 1) == 1 || w == p % 4)
                    write_reg(CFG_IDX_W'(w), pick_word());
            write_reg(REG_DIR, {$urandom, $urandom});
            if (p == PHASES - 1)
                quiet = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_block(pick_word(), pick_word());
            wait_drained();
        end

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
